// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds whenever an antecedent holds, same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after an antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/scvr_pkg.sv
package scvr_pkg;

    localparam int unsigned OUT_W = 18;
    localparam int unsigned TAG_W = 16;
    localparam int unsigned Q = 30;

    // angle bits used from the 16-bit angle ports, vector bits from the 24-bit ports
    localparam int ANGLE_BITS = 16;
    localparam int VEC_BITS = 24;

    typedef enum logic
    {
        OP_SPH_TO_CART = 1'b0,
        OP_CART_TO_SPH = 1'b1
    } op_t;

    localparam logic [31:0] C1  = 32'd1686629713;
    localparam logic [31:0] C3  = 32'd693598668;
    localparam logic [31:0] C5  = 32'd85569306;
    localparam logic [31:0] C7  = 32'd5026995;
    localparam logic [31:0] C9  = 32'd172272;
    localparam logic [31:0] C11 = 32'd3864;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

endpackage

// File: hw/rtl/spherical_cartesian_vector_rotate.sv
// Channel   | Direction | Handshake            | Payload
// config    | in / out  | psel,penable,pwrite  | paddr, pwdata, prdata
// command   | in        | start (busy low)     | op, angles, vec_a..c, photon_tag
// result    | out       | done strobe          | unit_a..c, zero_length, tag_out
//
// Fully pipelined: one transaction accepted per cycle, busy is always low.
// The depth from the accepting edge to the done cycle is set by the polynomial
// stages, rotation, a bit-per-stage square root and a bit-per-stage divider.
// rst_n clears the valid chain and spherical_mode (to 1); data regs are not reset.
// The receiver cannot stall; results appear as one-cycle done pulses.
`include "assert_macros.svh"

module spherical_cartesian_vector_rotate
    import scvr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [15:0]                 polar_angle,
    input  logic [15:0]                 azimuth_angle,
    input  logic signed [23:0]          vec_a,
    input  logic signed [23:0]          vec_b,
    input  logic signed [23:0]          vec_c,
    input  logic [15:0]                 photon_tag,
    output logic                        done,
    output logic signed [OUT_W-1:0]     unit_a,
    output logic signed [OUT_W-1:0]     unit_b,
    output logic signed [OUT_W-1:0]     unit_c,
    output logic                        zero_length,
    output logic [TAG_W-1:0]            tag_out
);

    // stage map
    localparam int NP = 6;            // polynomial steps after y
    localparam int S_NORM = 1;        // after normalize + y
    localparam int S_POLY = S_NORM + 1 + NP; // after sin/cos ready (incl final x*p)
    localparam int S_ROT1 = S_POLY + 2;      // products then sum
    localparam int S_ROT2 = S_ROT1 + 2;
    localparam int S_SQ = S_ROT2 + 2;        // squares, sum
    localparam int SQB = 32;                 // sqrt result bits
    localparam int S_SQRT = S_SQ + SQB;
    localparam int DB = 19;                  // quotient bits
    localparam int S_DIV = S_SQRT + DB;
    localparam int LAT = S_DIV + 1;

    // ---------------- config ----------------
    logic mode_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 2'd0)
            mode_reg <= pwdata[0];
    end
    assign pready = 1'b1;
    assign prdata = {31'd0, mode_reg};
    assign busy = 1'b0;

    // ---------------- valid chain + side band ----------------
    logic [LAT:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-1:0], start};
    end

    typedef struct packed {
        logic op;
        logic mode;
        logic zero;
        logic [15:0] tag;
        logic signed [OUT_W-1:0] pa;
        logic signed [OUT_W-1:0] pb;
        logic signed [OUT_W-1:0] pc;
    } side_t;
    side_t side_reg [LAT+1];

    function automatic logic signed [OUT_W-1:0] pass_cvt(input logic signed [63:0] k);
        logic [63:0] m;
        logic [63:0] r;
        logic signed [63:0] s;
        begin
            m = k[63] ? 64'(-k) : 64'(k);
            r = (m + 64'd8) >> 4;
            s = k[63] ? -$signed(r) : $signed(r);
            if (s > 64'sd131071)
                pass_cvt = OUT_MAX;
            else if (s < -64'sd131072)
                pass_cvt = OUT_MIN;
            else
                pass_cvt = s[OUT_W-1:0];
        end
    endfunction

    logic signed [63:0] ka, kb, kc;
    assign ka = 64'($signed(vec_a[VEC_BITS-1:0]));
    assign kb = 64'($signed(vec_b[VEC_BITS-1:0]));
    assign kc = 64'($signed(vec_c[VEC_BITS-1:0]));

    always_ff @(posedge clk)
    begin
        side_reg[0].op <= op;
        side_reg[0].mode <= mode_reg;
        side_reg[0].zero <= (ka == 0) && (kb == 0) && (kc == 0);
        side_reg[0].tag <= photon_tag;
        side_reg[0].pa <= pass_cvt(ka);
        side_reg[0].pb <= pass_cvt(kb);
        side_reg[0].pc <= pass_cvt(kc);
        for (int i = 1; i <= LAT; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // ---------------- angle front end: 4 sin lanes ----------------
    // lane 0 sin(theta) 1 cos(theta) 2 sin(phi) 3 cos(phi)
    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    logic [ANGLE_BITS-1:0] ang [4];
    assign ang[0] = polar_angle[ANGLE_BITS-1:0];
    assign ang[1] = polar_angle[ANGLE_BITS-1:0] + QTR;
    assign ang[2] = azimuth_angle[ANGLE_BITS-1:0];
    assign ang[3] = azimuth_angle[ANGLE_BITS-1:0] + QTR;

    localparam int XSH = 32 - ANGLE_BITS;
    logic [30:0] x0 [4];
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            x0[l] = 31'({ang[l][ANGLE_BITS-3:0], {XSH{1'b0}}});
            if (ang[l][ANGLE_BITS-2])
                x0[l] = 31'h4000_0000 - x0[l];
        end
    end

    logic [30:0] x_reg [S_POLY+1][4];
    logic        neg_reg [S_POLY+1][4];
    logic [31:0] y_reg [4];
    logic [31:0] p_reg [NP][4];
    logic [61:0] xx [4];
    always_comb
        for (int l = 0; l < 4; l++)
            xx[l] = 62'(x0[l]) * 62'(x0[l]);

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            x_reg[0][l] <= x0[l];
            neg_reg[0][l] <= ang[l][ANGLE_BITS-1];
            y_reg[l] <= 32'(xx[l] >> Q);
            for (int s = 1; s <= S_POLY; s++)
            begin
                x_reg[s][l] <= x_reg[s-1][l];
                neg_reg[s][l] <= neg_reg[s-1][l];
            end
        end
    end

    // horner steps; y held alongside by stage index
    logic [31:0] y_pipe_reg [5][4];
    logic [31:0] cst [5];
    assign cst[0] = C9;
    assign cst[1] = C7;
    assign cst[2] = C5;
    assign cst[3] = C3;
    assign cst[4] = C1;
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            y_pipe_reg[0][l] <= y_reg[l];
            for (int s = 1; s < 5; s++)
                y_pipe_reg[s][l] <= y_pipe_reg[s-1][l];
        end
    end

    logic [63:0] py [5][4];
    always_comb
        for (int s = 0; s < 5; s++)
            for (int l = 0; l < 4; l++)
                py[s][l] = 64'(p_reg[s][l]) * 64'(y_pipe_reg[s][l]);

    // p_reg[0] aligned with y_pipe_reg[0] (both at stage 2)
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            p_reg[0][l] <= C11;
            for (int s = 1; s <= 5; s++)
                p_reg[s][l] <= cst[s-1] - 32'(py[s-1][l] >> Q);
        end
    end

    logic signed [31:0] sc_reg [4];
    logic [63:0] xp [4];
    always_comb
        for (int l = 0; l < 4; l++)
            xp[l] = 64'(x_reg[S_NORM+5][l]) * 64'(p_reg[5][l]);
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            sc_reg[l] <= neg_reg[S_NORM+5][l] ? -$signed(32'(xp[l] >> Q))
                                              : $signed(32'(xp[l] >> Q));
        end
    end

    // ---------------- vector normalize shift ----------------
    // shift so max magnitude >= 2^30; result fits 32-bit signed
    function automatic logic [5:0] lz_shift(input logic [31:0] m);
        logic [5:0] s;
        begin
            s = 6'd0;
            // highest set bit wins
            for (int b = 0; b <= 30; b++)
                if (m[b])
                    s = 6'(30 - b);
            lz_shift = s;
        end
    endfunction

    function automatic logic [31:0] mag32(input logic signed [63:0] v);
        mag32 = v[63] ? 32'(-v) : 32'(v);
    endfunction

    logic [31:0] mx;
    logic [5:0] sh;
    always_comb
    begin
        mx = mag32(ka);
        if (mag32(kb) > mx) mx = mag32(kb);
        if (mag32(kc) > mx) mx = mag32(kc);
        sh = lz_shift(mx);
    end

    logic signed [31:0] k_reg [S_POLY+1][3];
    always_ff @(posedge clk)
    begin
        k_reg[0][0] <= 32'(ka) <<< sh;
        k_reg[0][1] <= 32'(kb) <<< sh;
        k_reg[0][2] <= 32'(kc) <<< sh;
        for (int s = 1; s <= S_POLY; s++)
            k_reg[s] <= k_reg[s-1];
    end

    // sin/cos valid at stage index S_NORM+6 in sc_reg; align k
    localparam int KI = S_NORM + 6;

    function automatic logic signed [63:0] rshr(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            r = (m + 64'h2000_0000) >> Q;
            rshr = v[63] ? -$signed(r) : $signed(r);
        end
    endfunction

    // rotation stage 1 products
    logic signed [63:0] r1p_reg [4];
    logic signed [31:0] kz1_reg, kz2_reg;
    logic o1, o2;
    assign o1 = side_reg[KI].op;
    always_ff @(posedge clk)
    begin
        if (o1 == OP_SPH_TO_CART)
        begin
            r1p_reg[0] <= 64'(k_reg[KI][0]) * 64'(sc_reg[0]);
            r1p_reg[1] <= 64'(k_reg[KI][1]) * 64'(sc_reg[1]);
            r1p_reg[2] <= 64'(k_reg[KI][0]) * 64'(sc_reg[1]);
            r1p_reg[3] <= 64'(k_reg[KI][1]) * 64'(sc_reg[0]);
        end
        else
        begin
            r1p_reg[0] <= 64'(k_reg[KI][0]) * 64'(sc_reg[3]);
            r1p_reg[1] <= 64'(k_reg[KI][1]) * 64'(sc_reg[2]);
            r1p_reg[2] <= 64'(k_reg[KI][1]) * 64'(sc_reg[3]);
            r1p_reg[3] <= 64'(k_reg[KI][0]) * 64'(sc_reg[2]);
        end
        kz1_reg <= k_reg[KI][2];
    end

    logic signed [31:0] sc1_reg [4], sc2_reg [4];
    always_ff @(posedge clk)
    begin
        sc1_reg <= sc_reg;
        sc2_reg <= sc1_reg;
    end

    logic signed [63:0] a_reg, v2_reg, v2b_reg;
    always_ff @(posedge clk)
    begin
        a_reg <= rshr(r1p_reg[0] + r1p_reg[1]);
        v2_reg <= rshr(r1p_reg[2] - r1p_reg[3]);
        kz2_reg <= kz1_reg;
    end

    assign o2 = side_reg[KI+2].op;
    logic signed [63:0] r2p_reg [4];
    always_ff @(posedge clk)
    begin
        if (o2 == OP_SPH_TO_CART)
        begin
            r2p_reg[0] <= a_reg * 64'(sc2_reg[3]);
            r2p_reg[1] <= 64'(kz2_reg) * 64'(sc2_reg[2]);
            r2p_reg[2] <= a_reg * 64'(sc2_reg[2]);
            r2p_reg[3] <= 64'(kz2_reg) * 64'(sc2_reg[3]);
        end
        else
        begin
            r2p_reg[0] <= a_reg * 64'(sc2_reg[0]);
            r2p_reg[1] <= -(64'(kz2_reg) * 64'(sc2_reg[1]));
            r2p_reg[2] <= a_reg * 64'(sc2_reg[1]);
            r2p_reg[3] <= -(64'(kz2_reg) * 64'(sc2_reg[0]));
        end
        v2b_reg <= v2_reg;
    end

    logic signed [63:0] v_reg [3];
    always_ff @(posedge clk)
    begin
        v_reg[0] <= rshr(r2p_reg[0] - r2p_reg[1]);
        v_reg[1] <= rshr(r2p_reg[2] + r2p_reg[3]);
        v_reg[2] <= v2b_reg;
    end

    // squares
    logic [63:0] sq_reg [3];
    logic signed [63:0] vq_reg [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= 64'(mag32(v_reg[i])) * 64'(mag32(v_reg[i]));
        vq_reg <= v_reg;
    end

    // restoring sqrt, one result bit per stage
    logic [65:0] rem_reg [SQB+1];
    logic [63:0] num_reg [SQB+1];
    logic [31:0] root_reg [SQB+1];
    logic signed [63:0] vs_reg [SQB+1][3];
    always_ff @(posedge clk)
    begin
        num_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        rem_reg[0] <= '0;
        root_reg[0] <= '0;
        vs_reg[0] <= vq_reg;
        for (int s = 1; s <= SQB; s++)
        begin
            logic [65:0] r;
            logic [65:0] t;
            r = {rem_reg[s-1][63:0], num_reg[s-1][63:62]};
            t = 66'({root_reg[s-1], 2'b01});
            if (r >= t)
            begin
                rem_reg[s] <= r - t;
                root_reg[s] <= {root_reg[s-1][30:0], 1'b1};
            end
            else
            begin
                rem_reg[s] <= r;
                root_reg[s] <= {root_reg[s-1][30:0], 1'b0};
            end
            num_reg[s] <= num_reg[s-1] << 2;
            vs_reg[s] <= vs_reg[s-1];
        end
    end

    // division: q = (|v|<<16 + len/2) / len, restoring, DB bits
    // |v| <= len, so numerator < 2^17 * len, quotient < 2^18; the numerator's
    // top bits seed the remainder and only its low DB bits are stepped in
    logic [31:0] len_reg [DB+1];
    logic [49:0] dn_reg [DB+1][3];
    logic [DB-1:0] q_reg [DB+1][3];
    logic [50:0] dr_reg [DB+1][3];
    logic vneg_reg [DB+1][3];
    always_ff @(posedge clk)
    begin
        len_reg[0] <= root_reg[SQB];
        for (int i = 0; i < 3; i++)
        begin
            logic [49:0] nm;
            nm = (50'(mag32(vs_reg[SQB][i])) << 16) + 50'(root_reg[SQB] >> 1);
            dn_reg[0][i] <= nm << (50 - DB);
            q_reg[0][i] <= '0;
            dr_reg[0][i] <= 51'(nm >> DB);
            vneg_reg[0][i] <= vs_reg[SQB][i][63];
        end
        for (int s = 1; s <= DB; s++)
        begin
            len_reg[s] <= len_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                logic [50:0] r;
                r = {dr_reg[s-1][i][49:0], dn_reg[s-1][i][49]};
                if (r >= 51'(len_reg[s-1]))
                begin
                    dr_reg[s][i] <= r - 51'(len_reg[s-1]);
                    q_reg[s][i] <= {q_reg[s-1][i][DB-2:0], 1'b1};
                end
                else
                begin
                    dr_reg[s][i] <= r;
                    q_reg[s][i] <= {q_reg[s-1][i][DB-2:0], 1'b0};
                end
                dn_reg[s][i] <= dn_reg[s-1][i] << 1;
                vneg_reg[s][i] <= vneg_reg[s-1][i];
            end
        end
    end

    // ---------------- output ----------------
    function automatic logic signed [OUT_W-1:0] sat_q(input logic [DB-1:0] q, input logic n);
        logic signed [DB+1:0] s;
        begin
            s = n ? -$signed({2'b00, q}) : $signed({2'b00, q});
            if (s > (DB+2)'(131071))
                sat_q = OUT_MAX;
            else if (s < -(DB+2)'(131072))
                sat_q = OUT_MIN;
            else
                sat_q = s[OUT_W-1:0];
        end
    endfunction

    side_t so;
    assign so = side_reg[LAT-1];
    always_ff @(posedge clk)
    begin
        if (so.zero)
        begin
            unit_a <= '0;
            unit_b <= '0;
            unit_c <= '0;
        end
        else if (!so.mode)
        begin
            unit_a <= so.pa;
            unit_b <= so.pb;
            unit_c <= so.pc;
        end
        else if (len_reg[DB] == 0)
        begin
            unit_a <= '0;
            unit_b <= '0;
            unit_c <= '0;
        end
        else
        begin
            unit_a <= sat_q(q_reg[DB][0], vneg_reg[DB][0]);
            unit_b <= sat_q(q_reg[DB][1], vneg_reg[DB][1]);
            unit_c <= sat_q(q_reg[DB][2], vneg_reg[DB][2]);
        end
        zero_length <= so.zero;
        tag_out <= so.tag;
    end
    assign done = vld_reg[LAT];

    `ASSERT_IMPL(a_never_busy, 1'b1, !busy, "busy asserted")
    `ASSERT_NEXT(a_zero_out, done && zero_length, 1'b1, "zero check")
    `ASSERT_IMPL(a_zero_units, done && zero_length,
        unit_a == 0 && unit_b == 0 && unit_c == 0, "zero vector gave nonzero result")

endmodule

// File: verif/tb_spherical_cartesian_vector_rotate.sv
`timescale 1ns / 1ps

module tb_spherical_cartesian_vector_rotate;
    import scvr_pkg::*;

    localparam logic [1:0] REG_SPHERICAL_MODE = 2'd0;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic signed [17:0] ua;
        logic signed [17:0] ub;
        logic signed [17:0] uc;
        logic               zl;
        logic [15:0]        tag;
    } unit_vec_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy;
    op_t op;
    logic [15:0] polar_angle, azimuth_angle, photon_tag;
    logic signed [23:0] vec_a, vec_b, vec_c;
    logic done;
    logic signed [OUT_W-1:0] unit_a, unit_b, unit_c;
    logic zero_length;
    logic [TAG_W-1:0] tag_out;

    unit_vec_t expected_units[$];
    bit mode_rotate;
    int errors;
    bit no_gaps;

    spherical_cartesian_vector_rotate DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .op(op),
        .polar_angle(polar_angle), .azimuth_angle(azimuth_angle),
        .vec_a(vec_a), .vec_b(vec_b), .vec_c(vec_c), .photon_tag(photon_tag),
        .done(done), .unit_a(unit_a), .unit_b(unit_b), .unit_c(unit_c),
        .zero_length(zero_length), .tag_out(tag_out)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint shr_round(longint v, int n);
        longint h;
        h = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + h) >>> n;
        return -((-v + h) >>> n);
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071)
            return 131071;
        if (v < -131072)
            return -131072;
        return v;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Q30 sine over a 16-bit turn, odd polynomial on the quarter wave
    function automatic longint sine_q30(logic [15:0] t);
        logic [1:0] quad;
        logic [63:0] x, y, p;
        quad = t[15:14];
        x = 64'(t[13:0]) << 16;
        if (quad[0])
            x = (64'd1 << 30) - x;
        y = (x * x) >> 30;
        p = 64'(C11);
        p = 64'(C9) - ((p * y) >> 30);
        p = 64'(C7) - ((p * y) >> 30);
        p = 64'(C5) - ((p * y) >> 30);
        p = 64'(C3) - ((p * y) >> 30);
        p = 64'(C1) - ((p * y) >> 30);
        p = (x * p) >> 30;
        return quad[1] ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic unit_vec_t rotate_to_unit(op_t o, logic [15:0] th, logic [15:0] ph,
                                                 logic signed [23:0] a, logic signed [23:0] b,
                                                 logic signed [23:0] c, logic [15:0] tag);
        unit_vec_t r;
        longint k[3], v[3], res[3];
        longint st, ct, sp, cp, m, t;
        logic [63:0] n2, len, q;
        k[0] = a;
        k[1] = b;
        k[2] = c;
        res = '{0, 0, 0};
        r.zl = (a == 0 && b == 0 && c == 0);
        if (!r.zl && !mode_rotate)
        begin
            for (int i = 0; i < 3; i++)
                res[i] = clamp18(shr_round(k[i], 4));
        end
        else if (!r.zl)
        begin
            st = sine_q30(th);
            ct = sine_q30(th + 16'h4000);
            sp = sine_q30(ph);
            cp = sine_q30(ph + 16'h4000);
            m = abs64(k[0]);
            if (abs64(k[1]) > m) m = abs64(k[1]);
            if (abs64(k[2]) > m) m = abs64(k[2]);
            while (m < (longint'(1) << 30))
            begin
                m = m * 2;
                for (int i = 0; i < 3; i++)
                    k[i] = k[i] * 2;
            end
            if (o == OP_SPH_TO_CART)
            begin
                t = shr_round(k[0] * st + k[1] * ct, 30);
                v[2] = shr_round(k[0] * ct - k[1] * st, 30);
                v[0] = shr_round(t * cp - k[2] * sp, 30);
                v[1] = shr_round(t * sp + k[2] * cp, 30);
            end
            else
            begin
                t = shr_round(k[0] * cp + k[1] * sp, 30);
                v[2] = shr_round(k[1] * cp - k[0] * sp, 30);
                v[0] = shr_round(t * st + k[2] * ct, 30);
                v[1] = shr_round(t * ct - k[2] * st, 30);
            end
            n2 = 0;
            for (int i = 0; i < 3; i++)
                n2 = n2 + 64'(abs64(v[i])) * 64'(abs64(v[i]));
            len = int_sqrt(n2);
            if (len != 0)
                for (int i = 0; i < 3; i++)
                begin
                    q = ((64'(abs64(v[i])) << 16) + (len >> 1)) / len;
                    res[i] = clamp18(v[i] < 0 ? -longint'(q) : longint'(q));
                end
        end
        r.ua = res[0][17:0];
        r.ub = res[1][17:0];
        r.uc = res[2][17:0];
        r.tag = tag;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        unit_vec_t e;
        if (rst_n && done)
        begin
            if (expected_units.size() == 0)
                report_mismatch("unexpected transaction, tag", tag_out, -1);
            else
            begin
                e = expected_units.pop_front();
                if (unit_a !== e.ua) report_mismatch("unit_a", unit_a, e.ua);
                if (unit_b !== e.ub) report_mismatch("unit_b", unit_b, e.ub);
                if (unit_c !== e.uc) report_mismatch("unit_c", unit_c, e.uc);
                if (zero_length !== e.zl) report_mismatch("zero_length", zero_length, e.zl);
                if (tag_out !== e.tag) report_mismatch("tag_out", tag_out, e.tag);
            end
        end
    end

    task automatic write_mode(bit val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_SPHERICAL_MODE;
        pwdata <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_rotate = val;
        @(posedge clk);
        psel <= 1'b1;
        paddr <= REG_SPHERICAL_MODE;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[0] !== val)
            report_mismatch("spherical_mode readback", prdata[0], val);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_vector(op_t o, logic [15:0] th, logic [15:0] ph,
                               logic signed [23:0] a, logic signed [23:0] b,
                               logic signed [23:0] c, logic [15:0] tag);
        int gap;
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        polar_angle <= th;
        azimuth_angle <= ph;
        vec_a <= a;
        vec_b <= b;
        vec_c <= c;
        photon_tag <= tag;
        do @(posedge clk); while (busy);
        expected_units.push_back(rotate_to_unit(o, th, ph, a, b, c, tag));
    endtask

    task automatic idle_and_drain();
        start <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_component();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($signed($urandom_range(0, 15)) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed_rotation();
        send_vector(OP_SPH_TO_CART, 16'h0000, 16'h0000, 24'sh100000, 0, 0, 16'h0001);
        send_vector(OP_CART_TO_SPH, 16'hFFFF, 16'hFFFF, 0, 24'sh100000, 0, 16'hFFFF);
        send_vector(OP_SPH_TO_CART, 16'h4000, 16'h8000, 0, 0, 24'sh100000, 16'h0002);
        send_vector(OP_CART_TO_SPH, 16'hC000, 16'h4000, 24'sh7FFFFF, 24'sh7FFFFF,
                    24'sh7FFFFF, 16'h0003);
        send_vector(OP_SPH_TO_CART, 16'h2000, 16'h6000, -24'sh800000, -24'sh800000,
                    -24'sh800000, 16'h0004);
        send_vector(OP_CART_TO_SPH, 16'h1234, 16'hABCD, 24'sd1, 0, 0, 16'h0005);
        send_vector(OP_SPH_TO_CART, 16'h8000, 16'hC000, 0, -24'sd1, 24'sd1, 16'h0006);
        // zero vector flags and zeroes the outputs
        send_vector(OP_SPH_TO_CART, 16'h5555, 16'hAAAA, 0, 0, 0, 16'h0007);
        send_vector(OP_CART_TO_SPH, 16'hFFFF, 16'h0000, 0, 0, 0, 16'h0008);
        send_vector(OP_SPH_TO_CART, 16'h0001, 16'hFFFE, 24'sh7FFFFF, 0, -24'sh800000,
                    16'h0009);
        idle_and_drain();
    endtask

    task automatic test_directed_passthrough();
        write_mode(1'b0);
        send_vector(OP_SPH_TO_CART, 16'h1111, 16'h2222, 24'sh7FFFFF, -24'sh800000, 0,
                    16'h0010);
        send_vector(OP_CART_TO_SPH, 16'h3333, 16'h4444, 24'sd8, -24'sd8, 24'sd7, 16'h0011);
        send_vector(OP_SPH_TO_CART, 16'h0000, 16'hFFFF, -24'sd7, 24'sd24, -24'sd24,
                    16'h0012);
        send_vector(OP_CART_TO_SPH, 16'h0000, 16'h0000, 0, 0, 0, 16'h0013);
        send_vector(OP_SPH_TO_CART, 16'hFFFF, 16'hFFFF, 24'sh1FFFFF, -24'sh200001,
                    24'sh1FFFF7, 16'h0014);
        idle_and_drain();
    endtask

    task automatic test_random_vectors(int count, bit rotate);
        logic signed [23:0] a, b, c;
        write_mode(rotate);
        for (int i = 0; i < count; i++)
        begin
            a = rand_component();
            b = rand_component();
            c = rand_component();
            if ($urandom_range(0, 29) == 0)
            begin
                a = 0;
                b = 0;
                c = 0;
            end
            send_vector(op_t'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                        a, b, c, 16'($urandom));
        end
        idle_and_drain();
    endtask

    initial
    begin
        errors = 0;
        no_gaps = 0;
        mode_rotate = 1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        op = OP_SPH_TO_CART;
        polar_angle = '0;
        azimuth_angle = '0;
        vec_a = '0;
        vec_b = '0;
        vec_c = '0;
        photon_tag = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_rotation();
        test_directed_passthrough();
        test_random_vectors(300, 1'b1);
        test_random_vectors(150, 1'b0);
        no_gaps = 1;
        test_random_vectors(250, 1'b1);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
